// ----- rtl/pcc_pkg.sv -----
// Package for the clamped PID controller: shared types, codes and helpers.
// Used by the controller, the datapath, the divider and the top level.
package pcc_pkg;

   localparam int DATA_W = 32;
   localparam int DIV_N_W = 49;
   localparam int DIV_STEPS = 49;
   localparam int DIV_CNT_W = 6;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_GAIN_P       = 3'd0;
   localparam reg_index_type REG_GAIN_I       = 3'd1;
   localparam reg_index_type REG_GAIN_D       = 3'd2;
   localparam reg_index_type REG_SETPOINT     = 3'd3;
   localparam reg_index_type REG_OUTPUT_LIMIT = 3'd4;
   localparam reg_index_type REG_INTEGRAL_CAP = 3'd5;

   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_ERR_DT = 2'd0;
   localparam mul_sel_type MUL_P      = 2'd1;
   localparam mul_sel_type MUL_I      = 2'd2;
   localparam mul_sel_type MUL_D      = 2'd3;

   typedef logic [1:0] acc_op_type;
   localparam acc_op_type ACC_NONE = 2'd0;
   localparam acc_op_type ACC_LOAD = 2'd1;
   localparam acc_op_type ACC_ADD  = 2'd2;

   typedef struct packed {
      logic        load_in;
      logic        calc_err;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_upd;
      acc_op_type  acc_op;
      logic        div_start;
      logic        der_latch;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/pid_controller_clamped_top.sv -----
// Top level of the clamped PID controller in signed Q16.16.
// Depends on pcc_pkg; instantiates pcc_ctrl and pcc_datapath.
//
// One transaction on the req channel produces exactly one transaction on the
// rsp channel. A new transaction is accepted the cycle after the result is
// registered, so the block works on one update at a time. The update time
// is set by the 49-step bit-serial divider that forms the derivative, plus
// four passes through the single shared multiplier. A finished result waits
// in its output register while the next transaction is accepted. Configuration
// writes take effect at once and are meant to be made while no update is in
// flight.
module pid_controller_clamped_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [31:0]      req_measured,
   input  logic [31:0]             req_time_step,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_drive,
   output logic                    rsp_output_clamped,
   output logic                    rsp_integral_clamped,
   output logic                    rsp_zero_step,
   input  logic                    csr_we,
   input  pcc_pkg::reg_index_type  csr_index,
   input  logic [31:0]             csr_wdata
);
   import pcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcc_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_measured         (req_measured),
      .req_time_step        (req_time_step),
      .rsp_drive            (rsp_drive),
      .rsp_output_clamped   (rsp_output_clamped),
      .rsp_integral_clamped (rsp_integral_clamped),
      .rsp_zero_step        (rsp_zero_step)
   );

endmodule

// ----- rtl/pcc_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pcc_pkg for its widths and step count.
module pcc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pcc_pkg::DIV_N_W-1:0]    dividend,
   input  logic [pcc_pkg::DATA_W-1:0]     divisor,
   output logic                           done,
   output logic [pcc_pkg::DIV_N_W-1:0]    quotient
);
   import pcc_pkg::*;

   logic                   busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DATA_W-1:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]      den_ff, den_in;
   logic [DIV_N_W-1:0]     quo_ff, quo_in;
   logic [DATA_W:0]        rem_sh;
   logic [DATA_W:0]        rem_sub;
   logic                   ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_N_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign done    = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// ----- rtl/pcc_datapath.sv -----
// Datapath of the PID controller: configuration registers, loop state,
// shared multiplier, accumulator, clamps and the result register.
// Depends on pcc_pkg and instantiates pcc_divider.
module pcc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  pcc_pkg::cmd_type           cmd,
   output pcc_pkg::status_type        status,
   input  logic                       csr_we,
   input  pcc_pkg::reg_index_type     csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic signed [31:0]         req_measured,
   input  logic [31:0]                req_time_step,
   output logic signed [31:0]         rsp_drive,
   output logic                       rsp_output_clamped,
   output logic                       rsp_integral_clamped,
   output logic                       rsp_zero_step
);
   import pcc_pkg::*;

   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, setpoint_ff;
   logic [30:0]        limit_ff, cap_ff;
   logic signed [31:0] integral_ff, integral_in;
   logic signed [31:0] prev_ff;

   logic signed [31:0] meas_ff;
   logic [31:0]        dt_ff;
   logic               zero_ff;
   logic signed [31:0] err_ff;
   logic signed [63:0] prod_ff;
   logic signed [33:0] acc_ff, acc_in;
   logic               der_neg_ff;
   logic signed [31:0] der_ff, der_in;
   logic               int_clamp_ff, int_clamp_in;

   logic signed [31:0] drive_ff, drive_in;
   logic               out_clamp_ff, out_clamp_in;
   logic               out_int_ff, out_zero_ff;

   logic signed [32:0] err_wide;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [47:0] prod_q;
   logic signed [31:0] term;
   logic signed [48:0] sum_wide, cap_pos;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic [DIV_N_W-1:0] dividend;
   logic [DIV_N_W-1:0] quotient;
   logic signed [49:0] quo_s, der_val;
   logic signed [33:0] lim_pos;

   pcc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (dt_ff),
      .done     (status.div_done),
      .quotient (quotient)
   );

   assign err_wide = 33'(setpoint_ff) - 33'(meas_ff);
   assign diff     = 33'(err_ff) - 33'(prev_ff);
   assign diff_mag = diff[32] ? 33'(-diff) : diff;
   assign dividend = {diff_mag, 16'b0};
   assign quo_s    = $signed({1'b0, quotient});
   assign der_val  = der_neg_ff ? -quo_s : quo_s;
   assign der_in   = zero_ff ? 32'sd0 : sat32(64'(der_val));

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = 33'(err_ff);
            mul_b = $signed({1'b0, dt_ff});
         end
         MUL_P: begin
            mul_a = 33'(gain_p_ff);
            mul_b = 33'(err_ff);
         end
         MUL_I: begin
            mul_a = 33'(gain_i_ff);
            mul_b = 33'(integral_ff);
         end
         MUL_D: begin
            mul_a = 33'(gain_d_ff);
            mul_b = 33'(der_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_q   = prod_ff[63:16];
   assign term     = sat32(64'(prod_q));

   assign sum_wide = 49'(integral_ff) + 49'(prod_q);
   assign cap_pos  = $signed({18'b0, cap_ff});

   always_comb begin
      integral_in  = integral_ff;
      int_clamp_in = int_clamp_ff;
      if (cmd.integ_upd) begin
         int_clamp_in = 1'b1;
         if (sum_wide > cap_pos) begin
            integral_in = cap_pos[31:0];
         end else if (sum_wide < -cap_pos) begin
            integral_in = 32'(-cap_pos);
         end else begin
            integral_in  = sum_wide[31:0];
            int_clamp_in = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (cmd.acc_op)
         ACC_LOAD: acc_in = 34'(term);
         ACC_ADD:  acc_in = acc_ff + 34'(term);
         default:  acc_in = acc_ff;
      endcase
   end

   assign lim_pos = $signed({3'b0, limit_ff});

   always_comb begin
      out_clamp_in = 1'b1;
      if (acc_ff > lim_pos) begin
         drive_in = lim_pos[31:0];
      end else if (acc_ff < -lim_pos) begin
         drive_in = 32'(-lim_pos);
      end else begin
         drive_in     = acc_ff[31:0];
         out_clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         setpoint_ff <= '0;
         limit_ff    <= '1;
         cap_ff      <= '1;
         integral_ff <= '0;
         prev_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_GAIN_P:       gain_p_ff   <= csr_wdata;
               REG_GAIN_I:       gain_i_ff   <= csr_wdata;
               REG_GAIN_D:       gain_d_ff   <= csr_wdata;
               REG_SETPOINT:     setpoint_ff <= csr_wdata;
               REG_OUTPUT_LIMIT: limit_ff    <= csr_wdata[30:0];
               REG_INTEGRAL_CAP: cap_ff      <= csr_wdata[30:0];
               default: ;
            endcase
         end
         integral_ff <= integral_in;
         if (cmd.out_load) begin
            prev_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         meas_ff <= req_measured;
         dt_ff   <= req_time_step;
         zero_ff <= (req_time_step == '0);
      end
      if (cmd.calc_err) begin
         err_ff <= sat32(64'(err_wide));
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_full[63:0];
      end
      if (cmd.div_start) begin
         der_neg_ff <= diff[32];
      end
      if (cmd.der_latch) begin
         der_ff <= der_in;
      end
      acc_ff       <= acc_in;
      int_clamp_ff <= int_clamp_in;
      if (cmd.out_load) begin
         drive_ff     <= drive_in;
         out_clamp_ff <= out_clamp_in;
         out_int_ff   <= int_clamp_ff;
         out_zero_ff  <= zero_ff;
      end
   end

   assign rsp_drive            = drive_ff;
   assign rsp_output_clamped   = out_clamp_ff;
   assign rsp_integral_clamped = out_int_ff;
   assign rsp_zero_step        = out_zero_ff;

endmodule

// ----- rtl/pcc_ctrl.sv -----
// Sequencer of the PID controller: steps the datapath through one update
// and owns the handshake state of both channels. Depends on pcc_pkg.
module pcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pcc_pkg::status_type  status,
   output pcc_pkg::cmd_type     cmd
);
   import pcc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ERR      = 4'd1;
   localparam logic [3:0] S_MUL_ID   = 4'd2;
   localparam logic [3:0] S_INTEG    = 4'd3;
   localparam logic [3:0] S_MUL_P    = 4'd4;
   localparam logic [3:0] S_ACC_P    = 4'd5;
   localparam logic [3:0] S_MUL_I    = 4'd6;
   localparam logic [3:0] S_ACC_I    = 4'd7;
   localparam logic [3:0] S_DIV_GO   = 4'd8;
   localparam logic [3:0] S_DIV_WAIT = 4'd9;
   localparam logic [3:0] S_DER      = 4'd10;
   localparam logic [3:0] S_MUL_D    = 4'd11;
   localparam logic [3:0] S_ACC_D    = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_ERR_DT;
      cmd.acc_op  = ACC_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_in = 1'b1;
            if (req_valid) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.calc_err = 1'b1;
            state_in = S_MUL_ID;
         end
         S_MUL_ID: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_DT;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.integ_upd = 1'b1;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_P;
            state_in = S_ACC_P;
         end
         S_ACC_P: begin
            cmd.acc_op = ACC_LOAD;
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_I;
            state_in = S_ACC_I;
         end
         S_ACC_I: begin
            cmd.acc_op = ACC_ADD;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_DER;
            end
         end
         S_DER: begin
            cmd.der_latch = 1'b1;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D;
            state_in = S_ACC_D;
         end
         S_ACC_D: begin
            cmd.acc_op = ACC_ADD;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/pcc_checker.sv -----
// Port-level checks for the clamped PID controller, bound to the top level.
// Depends on pcc_pkg for the register index type.
module pcc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic signed [31:0]      req_measured,
   input logic [31:0]             req_time_step,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [31:0]      rsp_drive,
   input logic                    rsp_output_clamped,
   input logic                    rsp_integral_clamped,
   input logic                    rsp_zero_step,
   input logic                    csr_we,
   input pcc_pkg::reg_index_type  csr_index,
   input logic [31:0]             csr_wdata
);

   // A stalled result keeps its value and flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_output_clamped) && $stable(rsp_integral_clamped)
         && $stable(rsp_zero_step))
      else $error("stalled result changed");

   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an update was in flight");

   // A result never appears right after an input is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind pid_controller_clamped_top pcc_checker u_pcc_checker (.*);
